// ===== hdl/tlafd_pkg.sv =====
// Shared constants, types and fixed-point helpers for the two-link arm dynamics block.
package tlafd_pkg;

    // Odd sine polynomial coefficients, unsigned Q30
    localparam logic [31:0] SIN_A1 = 32'd1686629713;
    localparam logic [31:0] SIN_A3 = 32'd693598668;
    localparam logic [31:0] SIN_A5 = 32'd85569305;
    localparam logic [31:0] SIN_A7 = 32'd5026996;
    localparam logic [31:0] SIN_A9 = 32'd172272;
    localparam logic [31:0] Q30_ONE = 32'h4000_0000;

    // Horner order after the A9 seed
    localparam logic [31:0] SIN_COEF [0:3] = '{SIN_A7, SIN_A5, SIN_A3, SIN_A1};

    localparam int PARAM_W = 20;
    localparam int LIMIT_W = 31;
    localparam int CFG_W   = 31;
    localparam int IDX_W   = 3;

    typedef enum logic [IDX_W-1:0] {
        REG_INERTIA_SUM  = 3'd0,
        REG_INERTIA_TWO  = 3'd1,
        REG_COUPLING     = 3'd2,
        REG_DAMP_ONE     = 3'd3,
        REG_DAMP_TWO     = 3'd4,
        REG_RATE_LIMIT   = 3'd5
    } cfg_reg_t;

    localparam logic [PARAM_W-1:0] RST_INERTIA_SUM = 20'd15991;
    localparam logic [PARAM_W-1:0] RST_INERTIA_TWO = 20'd4915;
    localparam logic [PARAM_W-1:0] RST_COUPLING    = 20'd4194;
    localparam logic [PARAM_W-1:0] RST_DAMP        = 20'd0;
    localparam logic [LIMIT_W-1:0] RST_RATE_LIMIT  = 31'd411775;

    // Sine pipeline lane
    typedef struct packed {
        logic [30:0] t;
        logic [30:0] u;
        logic [31:0] p;
        logic        neg;
    } trig_t;

    // Divider lane
    typedef struct packed {
        logic [65:0] r;
        logic [32:0] q;
        logic        neg;
        logic        ovf;
    } div_t;

    function automatic logic signed [31:0] sat32(input logic signed [71:0] v);
        logic signed [31:0] res;
        if (v > 72'sd2147483647)
            res = 32'sh7FFF_FFFF;
        else if (v < -72'sd2147483648)
            res = 32'sh8000_0000;
        else
            res = v[31:0];
        return res;
    endfunction

    // Round to nearest on a Q16 product, ties up (floor after adding half)
    function automatic logic signed [71:0] rnd_shr16(input logic signed [71:0] v);
        return (v + 72'sd32768) >>> 16;
    endfunction

endpackage

// ===== hdl/tlafd_if.sv =====
// Valid/ready word channels for the two-link arm dynamics block.
interface tlafd_in_if;
    logic               valid;
    logic               ready;
    logic        [15:0] elbow_angle;
    logic signed [31:0] shoulder_rate;
    logic signed [31:0] elbow_rate;
    logic signed [31:0] shoulder_torque;
    logic signed [31:0] elbow_torque;

    modport source (output valid, elbow_angle, shoulder_rate, elbow_rate,
                    shoulder_torque, elbow_torque, input ready);
    modport sink   (input valid, elbow_angle, shoulder_rate, elbow_rate,
                    shoulder_torque, elbow_torque, output ready);
endinterface

interface tlafd_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] shoulder_rate_out;
    logic signed [31:0] elbow_rate_out;
    logic signed [31:0] shoulder_accel;
    logic signed [31:0] elbow_accel;

    modport source (output valid, shoulder_rate_out, elbow_rate_out,
                    shoulder_accel, elbow_accel, input ready);
    modport sink   (input valid, shoulder_rate_out, elbow_rate_out,
                    shoulder_accel, elbow_accel, output ready);
endinterface

// ===== hdl/two_link_arm_forward_dynamics.sv =====
// Two-link arm forward dynamics: fully pipelined evaluation of joint accelerations.
//
// Takes one word per clock (elbow angle, two joint rates, two joint torques) and
// returns one word per input (both rates unchanged, both accelerations in Q16.16).
// Throughput is one word every cycle while the sink keeps up. The pipe is 48
// register stages deep, from the input capture to the register that drives dout.valid.
// The depth is set by the 33-step restoring divider that solves the 2x2 system
// (16 integer and 17 fraction quotient bits, one per stage). Ahead of it sit six
// sine/cosine stages, seven multiply/add and sign stages for the mass matrix,
// Coriolis terms and numerators, and one divider entry stage; a final stage
// rounds, saturates and clamps. All stages advance together: when the output
// word is held by a stalled sink the whole pipeline freezes and din.ready drops,
// so nothing is lost or repeated. Registers on the cfg port should only be
// written while the pipeline is empty. A singular mass matrix yields zero
// acceleration; an acceleration pushing a rate beyond +/- rate_limit is clamped.
module two_link_arm_forward_dynamics (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [tlafd_pkg::IDX_W-1:0]            cfg_index,
    input  logic [tlafd_pkg::CFG_W-1:0]            cfg_data,
    tlafd_in_if.sink                               din,
    tlafd_out_if.source                            dout
);

    // Stage map
    localparam int ST_SC     = 5;   // sine/cosine done
    localparam int ST_G      = 6;   // k, pc, damping, 2w1+w2
    localparam int ST_H      = 7;   // mass matrix, k*w
    localparam int ST_I      = 8;   // Coriolis products, det
    localparam int ST_J      = 9;   // b1, b2
    localparam int ST_K      = 10;  // numerator products
    localparam int ST_L      = 11;  // numerators
    localparam int ST_M      = 12;  // magnitudes
    localparam int ST_N      = 13;  // overflow check, divider entry
    localparam int DIV_STEPS = 33;
    localparam int DIV_INT   = 16;
    localparam int ST_OUT    = ST_N + DIV_STEPS + 1;
    localparam int NSTG      = ST_OUT + 1;

    // ---------------- configuration registers
    logic [tlafd_pkg::PARAM_W-1:0] p1_reg, p2_reg, p3_reg, d1_reg, d2_reg;
    logic [tlafd_pkg::LIMIT_W-1:0] lim_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_reg  <= tlafd_pkg::RST_INERTIA_SUM;
            p2_reg  <= tlafd_pkg::RST_INERTIA_TWO;
            p3_reg  <= tlafd_pkg::RST_COUPLING;
            d1_reg  <= tlafd_pkg::RST_DAMP;
            d2_reg  <= tlafd_pkg::RST_DAMP;
            lim_reg <= tlafd_pkg::RST_RATE_LIMIT;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                tlafd_pkg::REG_INERTIA_SUM: p1_reg  <= cfg_data[tlafd_pkg::PARAM_W-1:0];
                tlafd_pkg::REG_INERTIA_TWO: p2_reg  <= cfg_data[tlafd_pkg::PARAM_W-1:0];
                tlafd_pkg::REG_COUPLING:    p3_reg  <= cfg_data[tlafd_pkg::PARAM_W-1:0];
                tlafd_pkg::REG_DAMP_ONE:    d1_reg  <= cfg_data[tlafd_pkg::PARAM_W-1:0];
                tlafd_pkg::REG_DAMP_TWO:    d2_reg  <= cfg_data[tlafd_pkg::PARAM_W-1:0];
                tlafd_pkg::REG_RATE_LIMIT:  lim_reg <= cfg_data[tlafd_pkg::LIMIT_W-1:0];
                default: ;  // unknown index ignored
            endcase
        end
    end

    // ---------------- pipeline control
    // Global advance: the pipe moves whenever the output slot is free or taken.
    logic            en;
    logic [NSTG-1:0] vld_reg;

    assign en        = !vld_reg[NSTG-1] || dout.ready;
    assign din.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[NSTG-2:0], din.valid};
    end

    // Rate and torque carry lines
    logic signed [31:0] w1_reg   [0:NSTG-1];
    logic signed [31:0] w2_reg   [0:NSTG-1];
    logic signed [31:0] tau1_reg [0:ST_J-1];
    logic signed [31:0] tau2_reg [0:ST_J-1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            w1_reg[0]   <= din.shoulder_rate;
            w2_reg[0]   <= din.elbow_rate;
            tau1_reg[0] <= din.shoulder_torque;
            tau2_reg[0] <= din.elbow_torque;
            for (int i = 1; i < NSTG; i++)
            begin
                w1_reg[i] <= w1_reg[i-1];
                w2_reg[i] <= w2_reg[i-1];
            end
            for (int i = 1; i < ST_J; i++)
            begin
                tau1_reg[i] <= tau1_reg[i-1];
                tau2_reg[i] <= tau2_reg[i-1];
            end
        end
    end

    // ---------------- sine / cosine (lane 0 sine, lane 1 cosine)
    tlafd_pkg::trig_t trig_reg [0:4][0:1];
    tlafd_pkg::trig_t trig_next [0:1];

    always_comb
    begin
        logic [15:0] ang;
        logic [14:0] x;
        logic [29:0] x2;
        for (int l = 0; l < 2; l++)
        begin
            ang = (l == 0) ? din.elbow_angle : din.elbow_angle + 16'h4000;
            // fold into the first quadrant
            x   = ang[14] ? 15'h4000 - {1'b0, ang[13:0]} : {1'b0, ang[13:0]};
            x2  = 30'(x) * 30'(x);
            trig_next[l] = '{t: {x, 16'b0}, u: {x2[28:0], 2'b00},
                             p: tlafd_pkg::SIN_A9, neg: ang[15]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            trig_reg[0][0] <= trig_next[0];
            trig_reg[0][1] <= trig_next[1];
        end
    end

    for (genvar h = 0; h < 4; h++)
    begin : g_horner
        for (genvar l = 0; l < 2; l++)
        begin : g_lane
            logic [62:0] prod;
            assign prod = 63'(trig_reg[h][l].p) * 63'(trig_reg[h][l].u);
            always_ff @(posedge clk)
            begin
                if (en)
                    trig_reg[h+1][l] <= '{t: trig_reg[h][l].t, u: trig_reg[h][l].u,
                                          p: tlafd_pkg::SIN_COEF[h] - prod[61:30],
                                          neg: trig_reg[h][l].neg};
            end
        end
    end

    logic signed [17:0] sc_reg [0:1];

    always_ff @(posedge clk)
    begin
        logic [62:0] prod;
        logic [31:0] v;
        logic [31:0] rnd;
        if (en)
        begin
            for (int l = 0; l < 2; l++)
            begin
                prod = 63'(trig_reg[4][l].p) * 63'(trig_reg[4][l].t);
                v    = prod[61:30];
                if (v > tlafd_pkg::Q30_ONE)
                    v = tlafd_pkg::Q30_ONE;
                rnd  = (v + 32'd8192) >> 14;
                sc_reg[l] <= trig_reg[4][l].neg ? -$signed({1'b0, rnd[16:0]})
                                                : $signed({1'b0, rnd[16:0]});
            end
        end
    end

    // ---------------- stage G: k, pc, damping terms, 2w1+w2
    logic signed [21:0] k_reg, pc_reg;
    logic signed [31:0] d1w_reg, d2w_reg, sw_reg;

    always_ff @(posedge clk)
    begin
        logic signed [39:0] kp, pp;
        logic signed [55:0] dp1, dp2;
        if (en)
        begin
            kp  = 40'($signed({1'b0, p3_reg})) * 40'(sc_reg[0]);
            pp  = 40'($signed({1'b0, p3_reg})) * 40'(sc_reg[1]);
            dp1 = 56'($signed({1'b0, d1_reg})) * 56'(w1_reg[ST_SC]);
            dp2 = 56'($signed({1'b0, d2_reg})) * 56'(w2_reg[ST_SC]);
            k_reg   <= 22'(tlafd_pkg::rnd_shr16(72'(kp)));
            pc_reg  <= 22'(tlafd_pkg::rnd_shr16(72'(pp)));
            d1w_reg <= tlafd_pkg::sat32(tlafd_pkg::rnd_shr16(72'(dp1)));
            d2w_reg <= tlafd_pkg::sat32(tlafd_pkg::rnd_shr16(72'(dp2)));
            sw_reg  <= tlafd_pkg::sat32(72'(w1_reg[ST_SC]) + 72'(w1_reg[ST_SC])
                                        + 72'(w2_reg[ST_SC]));
        end
    end

    // ---------------- stage H: mass matrix, k*w
    logic signed [23:0] m11_reg, m12_reg;
    logic signed [31:0] kw1_reg, kw2_reg, sw_h_reg, d1w_h_reg, d2w_h_reg;

    always_ff @(posedge clk)
    begin
        logic signed [55:0] a, b;
        if (en)
        begin
            a = 56'(k_reg) * 56'(w1_reg[ST_G]);
            b = 56'(k_reg) * 56'(w2_reg[ST_G]);
            m11_reg   <= 24'($signed({1'b0, p1_reg})) + 24'($signed({1'b0, p2_reg}))
                         + (24'(pc_reg) <<< 1);
            m12_reg   <= 24'($signed({1'b0, p2_reg})) + 24'(pc_reg);
            kw1_reg   <= tlafd_pkg::sat32(tlafd_pkg::rnd_shr16(72'(a)));
            kw2_reg   <= tlafd_pkg::sat32(tlafd_pkg::rnd_shr16(72'(b)));
            sw_h_reg  <= sw_reg;
            d1w_h_reg <= d1w_reg;
            d2w_h_reg <= d2w_reg;
        end
    end

    // ---------------- stage I: Coriolis products, determinant
    logic signed [31:0] t1_reg, t2_reg, d1w_i_reg, d2w_i_reg;
    logic signed [23:0] m11_i_reg, m12_i_reg;
    logic signed [49:0] det_i_reg;

    always_ff @(posedge clk)
    begin
        logic signed [63:0] a, b;
        logic signed [49:0] x, y;
        if (en)
        begin
            a = 64'(kw2_reg) * 64'(sw_h_reg);
            b = 64'(kw1_reg) * 64'(w1_reg[ST_H]);
            x = 50'(m11_reg) * 50'($signed({1'b0, p2_reg}));
            y = 50'(m12_reg) * 50'(m12_reg);
            t1_reg    <= tlafd_pkg::sat32(tlafd_pkg::rnd_shr16(72'(a)));
            t2_reg    <= tlafd_pkg::sat32(tlafd_pkg::rnd_shr16(72'(b)));
            det_i_reg <= x - y;
            m11_i_reg <= m11_reg;
            m12_i_reg <= m12_reg;
            d1w_i_reg <= d1w_h_reg;
            d2w_i_reg <= d2w_h_reg;
        end
    end

    // ---------------- stage J: right-hand sides
    logic signed [31:0] b1_reg, b2_reg;
    logic signed [23:0] m11_j_reg, m12_j_reg;
    logic signed [49:0] det_j_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b1_reg    <= tlafd_pkg::sat32(72'(tau1_reg[ST_J-1]) - 72'(d1w_i_reg) + 72'(t1_reg));
            b2_reg    <= tlafd_pkg::sat32(72'(tau2_reg[ST_J-1]) - 72'(t2_reg) - 72'(d2w_i_reg));
            m11_j_reg <= m11_i_reg;
            m12_j_reg <= m12_i_reg;
            det_j_reg <= det_i_reg;
        end
    end

    // ---------------- stage K: numerator products
    logic signed [55:0] pa_reg, pb_reg, pc2_reg, pd_reg;
    logic signed [49:0] det_k_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pa_reg    <= 56'($signed({1'b0, p2_reg})) * 56'(b1_reg);
            pb_reg    <= 56'(m12_j_reg) * 56'(b2_reg);
            pc2_reg   <= 56'(m11_j_reg) * 56'(b2_reg);
            pd_reg    <= 56'(m12_j_reg) * 56'(b1_reg);
            det_k_reg <= det_j_reg;
        end
    end

    // ---------------- stage L: numerators
    logic signed [57:0] num_reg [0:1];
    logic signed [49:0] det_l_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_reg[0] <= 58'(pa_reg) - 58'(pb_reg);
            num_reg[1] <= 58'(pc2_reg) - 58'(pd_reg);
            det_l_reg  <= det_k_reg;
        end
    end

    // ---------------- stage M: sign and magnitude
    logic [57:0] n_m_reg [0:1];
    logic        neg_m_reg [0:1];
    logic [49:0] d_m_reg;
    logic        zero_m_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int l = 0; l < 2; l++)
            begin
                n_m_reg[l]   <= num_reg[l][57] ? 58'(-num_reg[l]) : 58'(num_reg[l]);
                neg_m_reg[l] <= num_reg[l][57] ^ det_l_reg[49];
            end
            d_m_reg    <= det_l_reg[49] ? 50'(-det_l_reg) : 50'(det_l_reg);
            zero_m_reg <= (det_l_reg == '0);
        end
    end

    // ---------------- stage N and divider: restoring division, one bit a stage
    tlafd_pkg::div_t dv_reg [0:DIV_STEPS][0:1];
    logic [49:0]     dd_reg [0:DIV_STEPS];
    logic            zero_reg [0:DIV_STEPS];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int l = 0; l < 2; l++)
                // quotient of 65536 or more always saturates
                dv_reg[0][l] <= '{r: 66'(n_m_reg[l]), q: '0, neg: neg_m_reg[l],
                                  ovf: (66'(n_m_reg[l]) >= (66'(d_m_reg) << 16))};
            dd_reg[0]   <= d_m_reg;
            zero_reg[0] <= zero_m_reg;
        end
    end

    for (genvar i = 0; i < DIV_STEPS; i++)
    begin : g_div
        // integer bits compare against d shifted; fraction bits shift the remainder
        localparam int SH = (i < DIV_INT) ? (DIV_INT - 1 - i) : 0;
        for (genvar l = 0; l < 2; l++)
        begin : g_lane
            logic [65:0] rin, dsh;
            logic        ge;
            assign rin = (i < DIV_INT) ? dv_reg[i][l].r : {dv_reg[i][l].r[64:0], 1'b0};
            assign dsh = 66'(dd_reg[i]) << SH;
            assign ge  = (rin >= dsh);
            always_ff @(posedge clk)
            begin
                if (en)
                    dv_reg[i+1][l] <= '{r: ge ? rin - dsh : rin,
                                        q: {dv_reg[i][l].q[31:0], ge},
                                        neg: dv_reg[i][l].neg, ovf: dv_reg[i][l].ovf};
            end
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dd_reg[i+1]   <= dd_reg[i];
                zero_reg[i+1] <= zero_reg[i];
            end
        end
    end

    // ---------------- output stage: round, saturate, clamp
    logic signed [31:0] acc_reg [0:1];
    logic signed [32:0] lim_s;

    assign lim_s = $signed({2'b00, lim_reg});

    always_ff @(posedge clk)
    begin
        logic [33:0]        mag;
        logic               sat;
        logic signed [31:0] a;
        logic signed [32:0] w;
        if (en)
        begin
            for (int l = 0; l < 2; l++)
            begin
                mag = (34'(dv_reg[DIV_STEPS][l].q) + 34'd1) >> 1;
                sat = dv_reg[DIV_STEPS][l].ovf || (dv_reg[DIV_STEPS][l].q[32:17] > 16'd32768);
                if (dv_reg[DIV_STEPS][l].neg)
                    a = (sat || mag > 34'h8000_0000) ? 32'sh8000_0000 : -$signed(mag[31:0]);
                else
                    a = (sat || mag > 34'h7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(mag[31:0]);
                if (zero_reg[DIV_STEPS])
                    a = '0;
                w = (l == 0) ? 33'(w1_reg[ST_OUT-1]) : 33'(w2_reg[ST_OUT-1]);
                if ((w > lim_s && a > 0) || (w < -lim_s && a < 0))
                    a = '0;
                acc_reg[l] <= a;
            end
        end
    end

    assign dout.valid             = vld_reg[NSTG-1];
    assign dout.shoulder_rate_out = w1_reg[NSTG-1];
    assign dout.elbow_rate_out    = w2_reg[NSTG-1];
    assign dout.shoulder_accel    = acc_reg[0];
    assign dout.elbow_accel       = acc_reg[1];

`ifndef ASSERT_OFF
    // fast shoulder never gets pushed further out
    assert property (@(posedge clk) disable iff (!rst_n)
        dout.valid && (33'(dout.shoulder_rate_out) > lim_s) |-> (dout.shoulder_accel <= 0))
        else $error("shoulder acceleration not clamped above rate limit");

    assert property (@(posedge clk) disable iff (!rst_n)
        dout.valid && (33'(dout.elbow_rate_out) < -lim_s) |-> (dout.elbow_accel >= 0))
        else $error("elbow acceleration not clamped below negative rate limit");

    // singular mass matrix gives zero acceleration
    assert property (@(posedge clk) disable iff (!rst_n)
        en && vld_reg[ST_OUT-1] && zero_reg[DIV_STEPS]
        |=> (dout.shoulder_accel == 0) && (dout.elbow_accel == 0))
        else $error("nonzero acceleration for singular mass matrix");
`endif

endmodule
